FILE: sv/lmfr_pkg.sv
// Shared types and codes for the LED matrix frame receiver and scanner.
// No dependencies.
`timescale 1ns / 1ps

package lmfr_pkg;

  localparam logic [63:0] ResetPattern = 64'd6788975656567;
  localparam logic [3:0]  LastSegment  = 4'd10;
  localparam logic [6:0]  SegmentBits  = 7'd6;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    MK_CONT   = 2'd0,
    MK_BEGIN  = 2'd1,
    MK_END    = 2'd2,
    MK_IGNORE = 2'd3
  } marker_e;

  typedef enum logic [1:0] {
    KIND_ECHO    = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_ROW     = 2'd2
  } kind_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic [7:0] anode_drive;
    logic [7:0] cathode_drive;
    logic       row_loaded;
    logic       last;
  } out_t;

  // held row drive, passed from the state block to the output sequencer
  typedef struct packed {
    logic [7:0] anode;
    logic [7:0] cathode;
  } drive_t;

endpackage

FILE: sv/lmfr_core.sv
// Frame assembly and row scan state; forms the first result of each word.
// Depends on lmfr_pkg.
`timescale 1ns / 1ps

module lmfr_core import lmfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  in_t         in_i,
  output out_t        first_o,
  output logic [63:0] shown_o,
  output drive_t      drive_o
);

  logic [63:0] shown_q, shown_d;
  logic [63:0] asm_q, asm_d;
  logic [3:0]  seg_q, seg_d;
  logic [2:0]  row_q, row_d;
  drive_t      drive_q, drive_d;

  logic [1:0]  marker;
  logic [5:0]  payload;
  logic [6:0]  shamt;
  logic [63:0] placed;
  logic [7:0]  row_bits;
  logic        loaded;

  assign marker  = in_i.rx_byte[7:6];
  assign payload = in_i.rx_byte[5:0];
  assign shamt   = 7'(seg_q) * SegmentBits;
  // payloads past segment ten would land beyond the word
  assign placed  = (seg_q <= LastSegment) ? (64'(payload) << shamt) : 64'd0;

  assign row_bits = shown_q[{row_q, 3'b000} +: 8];
  assign loaded   = (row_bits != 8'd0);

  always_comb begin
    shown_d = shown_q;
    asm_d   = asm_q;
    seg_d   = seg_q;
    row_d   = row_q;
    drive_d = drive_q;
    first_o = '0;
    if (in_i.cmd == CMD_TICK) begin
      if (loaded) begin
        drive_d.anode   = row_bits;
        drive_d.cathode = ~(8'd1 << row_q);
      end
      row_d                 = row_q + 3'd1;
      first_o.kind          = KIND_ROW;
      first_o.tx_byte       = 8'd0;
      first_o.anode_drive   = drive_d.anode;
      first_o.cathode_drive = drive_d.cathode;
      first_o.row_loaded    = loaded;
      first_o.last          = 1'b1;
    end else begin
      case (marker)
        MK_BEGIN: asm_d = 64'(payload);
        MK_CONT:  asm_d = asm_q | placed;
        MK_END: begin
          asm_d   = asm_q | placed;
          shown_d = asm_q | placed;
        end
        default: ;
      endcase
      // begin sets the count to one, past its own segment zero; every other byte advances it
      seg_d = (marker == MK_BEGIN) ? 4'd1 : seg_q + 4'd1;
      first_o.kind          = KIND_ECHO;
      first_o.tx_byte       = in_i.rx_byte;
      first_o.anode_drive   = drive_q.anode;
      first_o.cathode_drive = drive_q.cathode;
      first_o.row_loaded    = 1'b0;
      first_o.last          = (marker != MK_END);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q         <= ResetPattern;
      asm_q           <= 64'd0;
      seg_q           <= 4'd0;
      row_q           <= 3'd0;
      drive_q.anode   <= 8'd0;
      drive_q.cathode <= 8'hFF;
    end else if (accept_i) begin
      shown_q <= shown_d;
      asm_q   <= asm_d;
      seg_q   <= seg_d;
      row_q   <= row_d;
      drive_q <= drive_d;
    end
  end

  assign shown_o = shown_q;
  assign drive_o = drive_q;

endmodule

FILE: sv/lmfr_tx.sv
// Result register and sequencer: holds the current result word and walks
// the eight pattern bytes after an end byte. Depends on lmfr_pkg.
`timescale 1ns / 1ps

module lmfr_tx import lmfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  out_t        first_i,
  input  logic [63:0] shown_i,
  input  drive_t      drive_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output out_t        out_data_o,
  output logic        free_o
);

  logic       valid_q;
  out_t       res_q, res_d;
  logic [2:0] cnt_q;
  logic       take;

  assign take   = valid_q && !out_stall_i;
  // a new word may enter as the final result of the previous one leaves
  assign free_o = !valid_q || (take && res_q.last);

  always_comb begin
    res_d               = '0;
    res_d.kind          = KIND_PATTERN;
    res_d.tx_byte       = shown_i[{cnt_q, 3'b000} +: 8];
    res_d.anode_drive   = drive_i.anode;
    res_d.cathode_drive = drive_i.cathode;
    res_d.row_loaded    = 1'b0;
    res_d.last          = (cnt_q == 3'd7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 3'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      cnt_q   <= 3'd0;
    end else if (take) begin
      if (res_q.last) begin
        valid_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= first_i;
    end else if (take && !res_q.last) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

endmodule

FILE: sv/led_matrix_frame_receiver_scanner.sv
// Top level of the LED matrix frame receiver and row scanner.
// Depends on lmfr_pkg, lmfr_core and lmfr_tx.
//
//   port        dir  handshake                 word
//   in_data_i   in   in_valid_i / in_stall_o   cmd, rx_byte
//   out_data_o  out  out_valid_o / out_stall_i kind, tx_byte, drive, row_loaded, last
//
// A word updates the state as it is accepted; its first result is registered
// and shows the next cycle. Ticks and non-end bytes give one result, an end
// byte gives nine, one per cycle from the result register while out_stall_i is
// low. The next word is taken in the cycle the last result of the previous one
// leaves, so a word every cycle while each gives one result and nothing stalls.
// Reset is asynchronous and sets all state but the result word; no clearing pass.
`timescale 1ns / 1ps

module led_matrix_frame_receiver_scanner import lmfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic        accept;
  logic        free;
  out_t        first;
  logic [63:0] shown;
  drive_t      drive;

  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  lmfr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .first_o  (first),
    .shown_o  (shown),
    .drive_o  (drive)
  );

  lmfr_tx u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .first_i     (first),
    .shown_i     (shown),
    .drive_i     (drive),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .free_o      (free)
  );

  a_end_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.cmd == CMD_BYTE
     && in_data_i.rx_byte[7:6] == MK_END)
    |=> (out_valid_o && out_data_o.kind == KIND_ECHO && !out_data_o.last))
    else $error("end byte echo not followed by pattern bytes");

  a_pattern_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last)
    |=> (out_valid_o && out_data_o.kind == KIND_PATTERN))
    else $error("pattern run broken");

  a_one_cold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_ROW && out_data_o.row_loaded)
    |-> ($countones(~out_data_o.cathode_drive) == 1))
    else $error("loaded row cathode not one-cold");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while no result pending");

endmodule

FILE: tb/tb.sv
// Self-checking bench for led_matrix_frame_receiver_scanner.
// Depends on lmfr_pkg and the block's RTL; predicts each result word and
// compares it field by field while both sides idle and stall at random.
`timescale 1ns / 1ps

module tb;
  import lmfr_pkg::*;

  localparam int IdleLimit   = 1000;
  localparam int RandomWords = 300;
  localparam int DrainCycles = 20;
  localparam int PrintCap    = 40;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  led_matrix_frame_receiver_scanner u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // predicted matrix state
  logic [63:0] shown_pat;
  logic [63:0] asm_word;
  logic [3:0]  seg_cnt;
  logic [2:0]  scan_row;
  logic [7:0]  held_anode;
  logic [7:0]  held_cathode;

  out_t matrix_out_q[$];
  out_t due_word;
  int   bad_words;
  int   idle_cycles;
  int   sent_words;
  int   burst_left;
  int   stall_mode;
  int   stall_left;
  int   stall_phase;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predict the result words caused by one accepted input word
  function automatic void step_matrix(input in_t w);
    marker_e     mk;
    logic [5:0]  pay;
    logic [7:0]  anode;
    logic        loaded;
    logic [63:0] placed;
    if (w.cmd == CMD_TICK) begin
      anode  = shown_pat[scan_row*8 +: 8];
      loaded = 1'b0;
      if (anode != 8'd0) begin
        held_anode   = anode;
        held_cathode = ~(8'd1 << scan_row);
        loaded       = 1'b1;
      end
      matrix_out_q.push_back('{kind: KIND_ROW, tx_byte: 8'd0, anode_drive: held_anode,
                               cathode_drive: held_cathode, row_loaded: loaded,
                               last: 1'b1});
      scan_row = scan_row + 3'd1;
    end else begin
      mk  = marker_e'(w.rx_byte[7:6]);
      pay = w.rx_byte[5:0];
      // segments past 10 fall off the top of the word
      placed = (seg_cnt > 4'd10) ? 64'd0 : (64'(pay) << (int'(seg_cnt) * 6));
      case (mk)
        MK_BEGIN: begin
          seg_cnt  = 4'd0;
          asm_word = 64'(pay);
        end
        MK_CONT: asm_word = asm_word | placed;
        MK_END: begin
          asm_word  = asm_word | placed;
          shown_pat = asm_word;
        end
        default: ;
      endcase
      seg_cnt = seg_cnt + 4'd1;
      matrix_out_q.push_back('{kind: KIND_ECHO, tx_byte: w.rx_byte, anode_drive: held_anode,
                               cathode_drive: held_cathode, row_loaded: 1'b0,
                               last: (mk != MK_END)});
      if (mk == MK_END) begin
        for (int i = 0; i < 8; i++) begin
          matrix_out_q.push_back('{kind: KIND_PATTERN, tx_byte: shown_pat[i*8 +: 8],
                                   anode_drive: held_anode, cathode_drive: held_cathode,
                                   row_loaded: 1'b0, last: (i == 7)});
        end
      end
    end
  endfunction

  task automatic flag_word(input string what, input out_t got, input out_t want);
    if (bad_words < PrintCap) begin
      $display("%0t: %s: got %h, wanted %h", $realtime, what, got, want);
    end
    bad_words++;
  endtask

  // monitor: inputs feed the predictor before outputs are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        step_matrix(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (matrix_out_q.size() == 0) begin
          flag_word("word with nothing pending", out_data_o, '0);
        end else begin
          due_word = matrix_out_q.pop_front();
          if (out_data_o.kind !== due_word.kind) flag_word("kind", out_data_o, due_word);
          if (out_data_o.tx_byte !== due_word.tx_byte) begin
            flag_word("tx_byte", out_data_o, due_word);
          end
          if (out_data_o.anode_drive !== due_word.anode_drive) begin
            flag_word("anode_drive", out_data_o, due_word);
          end
          if (out_data_o.cathode_drive !== due_word.cathode_drive) begin
            flag_word("cathode_drive", out_data_o, due_word);
          end
          if (out_data_o.row_loaded !== due_word.row_loaded) begin
            flag_word("row_loaded", out_data_o, due_word);
          end
          if (out_data_o.last !== due_word.last) flag_word("last", out_data_o, due_word);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver stall: free flow, random, or periodic runs, switching now and then
  always @(posedge clk_i) begin
    stall_phase++;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(40, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= ((stall_phase % 11) < 6);
    endcase
  end

  function automatic in_t byte_word(input marker_e mk, input logic [5:0] pay);
    return '{cmd: CMD_BYTE, rx_byte: {mk, pay}};
  endfunction

  function automatic in_t tick_word();
    return '{cmd: CMD_TICK, rx_byte: 8'($urandom_range(0, 255))};
  endfunction

  function automatic logic [5:0] rand_payload();
    case ($urandom_range(0, 3))
      0:       return 6'd0;
      1:       return 6'h3f;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  // send one word; the sender runs in bursts with gaps between them
  task automatic send_word(input in_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_words++;
  endtask

  // reset pattern has blank rows 6 and 7; the held drive must carry through
  task automatic test_reset_scan();
    repeat (8) send_word(tick_word());
  endtask

  // begin with zero payload, fill to segment 10 (top bits lost), ignore at 11,
  // then an end byte whose payload is dropped but which still shows the word
  task automatic test_frame_limits();
    send_word(byte_word(MK_BEGIN, 6'd0));
    repeat (10) send_word(byte_word(MK_CONT, 6'h3f));
    send_word(byte_word(MK_IGNORE, 6'd0));
    send_word(byte_word(MK_END, 6'h3f));
  endtask

  task automatic test_scan_frame();
    repeat (8) send_word(tick_word());
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int pick;
    int n_cont;
    stop_at = sent_words + RandomWords;
    while (sent_words < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        // frame, now and then without begin or end; long ones wrap the count
        if ($urandom_range(0, 7) != 0) send_word(byte_word(MK_BEGIN, rand_payload()));
        n_cont = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 17) : $urandom_range(0, 9);
        repeat (n_cont) begin
          if ($urandom_range(0, 9) == 0) begin
            send_word(byte_word(MK_IGNORE, 6'($urandom_range(0, 63))));
          end else begin
            send_word(byte_word(MK_CONT, rand_payload()));
          end
        end
        if ($urandom_range(0, 7) != 0) send_word(byte_word(MK_END, rand_payload()));
      end else if (pick < 8) begin
        repeat ($urandom_range(1, 10)) send_word(tick_word());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word('{cmd: CMD_BYTE, rx_byte: 8'($urandom_range(0, 255))});
        end
      end
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    out_stall_i  <= 1'b0;
    shown_pat    = ResetPattern;
    asm_word     = 64'd0;
    seg_cnt      = 4'd0;
    scan_row     = 3'd0;
    held_anode   = 8'd0;
    held_cathode = 8'hff;
    bad_words    = 0;
    idle_cycles  = 0;
    sent_words   = 0;
    burst_left   = 0;
    stall_mode   = 0;
    stall_left   = 0;
    stall_phase  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_scan();
    test_frame_limits();
    test_scan_frame();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (matrix_out_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (bad_words == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
